FILE: rtl/drpa_pkg.sv
// drpa_pkg: shared types and codes for the dual region page allocator.
// Used by drpa_ctrl, drpa_dp and dual_region_page_allocator; no dependencies.
package drpa_pkg;

    localparam int ADDR_W = 48;
    localparam int CNT_W  = 13;
    localparam int ST_W   = 3;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_MISALIGN = 3'd2,
        ST_RANGE    = 3'd3,
        ST_BADCFG   = 3'd4
    } t_status;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_KPAGES = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TPAGES = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic latch_item;
        logic alloc_chk;
        logic alloc_upd;
        logic free_chk;
        logic free_upd;
        logic init_chk;
        logic init_dec;
        logic fill_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic head_empty;
        logic cfg_ok;
        logic fill_none;
        logic fill_last;
    } t_stat;

endpackage

FILE: rtl/dual_region_page_allocator.sv
// dual_region_page_allocator: top level, two LIFO page free lists in one link RAM.
// Depends on drpa_pkg, drpa_ctrl, drpa_dp (and drpa_ram through drpa_dp).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready    | i_opcode, i_region_select, i_page_addr
//  out      | o_out_valid / i_out_ready  | o_alloc_addr, o_status, o_free_count
//  cfg      | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// The time from one accepted item to the next depends on the opcode and is set by the single
// link RAM port (one access a cycle) and the init sweep that writes every page link; an
// alloc from an empty list skips the head update, and a bad config skips the sweep.
// Reset (sync, active low) empties both lists and zeroes counts and bounds;
// the link RAM is not cleared, init writes every entry that is later read.
// A result waiting in the output register holds back only the next item's result.
module dual_region_page_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [drpa_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [drpa_pkg::ADDR_W-1:0]   i_cfg_data,
    // request items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [drpa_pkg::OP_W-1:0]     i_opcode,
    input  logic                          i_region_select,
    input  logic [drpa_pkg::ADDR_W-1:0]   i_page_addr,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [drpa_pkg::ADDR_W-1:0]   o_alloc_addr,
    output logic [drpa_pkg::ST_W-1:0]     o_status,
    output logic [drpa_pkg::CNT_W-1:0]    o_free_count
);

    drpa_pkg::t_cmd  cmd;
    drpa_pkg::t_stat stat;

    // sequencer: one item in flight, steps the datapath through each opcode
    drpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: heads, counts, bounds, link RAM and the output register
    drpa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_region_select (i_region_select),
        .i_page_addr     (i_page_addr),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_alloc_addr    (o_alloc_addr),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule

FILE: rtl/drpa_ram.sv
// drpa_ram: generic single-port RAM, one access per cycle, registered read.
// No dependencies.
module drpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/drpa_ctrl.sv
// drpa_ctrl: sequencing state machine of the page allocator.
// Depends on drpa_pkg (t_op, t_cmd, t_stat).
module drpa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [drpa_pkg::OP_W-1:0]   i_opcode,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  drpa_pkg::t_stat             i_stat,
    output drpa_pkg::t_cmd              o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ALLOC = 9'b000000010,
        S_AUPD  = 9'b000000100,
        S_FCHK  = 9'b000001000,
        S_FUPD  = 9'b000010000,
        S_ICHK  = 9'b000100000,
        S_IDEC  = 9'b001000000,
        S_FILL  = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.latch_item = accept;
        o_cmd.alloc_chk  = (r_state == S_ALLOC);
        o_cmd.alloc_upd  = (r_state == S_AUPD);
        o_cmd.free_chk   = (r_state == S_FCHK);
        o_cmd.free_upd   = (r_state == S_FUPD);
        o_cmd.init_chk   = (r_state == S_ICHK);
        o_cmd.init_dec   = (r_state == S_IDEC);
        o_cmd.fill_step  = (r_state == S_FILL);
        o_cmd.load_out   = (r_state == S_RESP) && slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (drpa_pkg::t_op'(i_opcode))
                        drpa_pkg::OP_ALLOC: n_state = S_ALLOC;
                        drpa_pkg::OP_FREE:  n_state = S_FCHK;
                        drpa_pkg::OP_INIT:  n_state = S_ICHK;
                        drpa_pkg::OP_NOP:   n_state = S_RESP;
                        default:            n_state = S_RESP;
                    endcase
                end
            end
            S_ALLOC: n_state = i_stat.head_empty ? S_RESP : S_AUPD;
            S_AUPD:  n_state = S_RESP;
            S_FCHK:  n_state = S_FUPD;
            S_FUPD:  n_state = S_RESP;
            S_ICHK:  n_state = S_IDEC;
            S_IDEC: begin
                if (!i_stat.cfg_ok || i_stat.fill_none) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL:  n_state = i_stat.fill_last ? S_RESP : S_FILL;
            S_RESP:  n_state = slot_free ? S_IDLE : S_RESP;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // one item at a time: an accepted item always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    // a held result is never overwritten by the next one
    a_resp_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_out_ready) |=> (r_state == S_RESP))
        else $error("result dropped while output stalled");

    // last link written ends the fill sweep
    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_stat.fill_last) |=> (r_state == S_RESP))
        else $error("fill sweep overran");

endmodule

FILE: rtl/drpa_dp.sv
// drpa_dp: datapath of the page allocator: config, region bounds, list heads,
// free counts, link memory and result registers. Depends on drpa_pkg, drpa_ram.
module drpa_dp #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [drpa_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [drpa_pkg::ADDR_W-1:0]   i_cfg_data,
    input  logic                          i_region_select,
    input  logic [drpa_pkg::ADDR_W-1:0]   i_page_addr,
    input  drpa_pkg::t_cmd                i_cmd,
    output drpa_pkg::t_stat               o_stat,
    output logic [drpa_pkg::ADDR_W-1:0]   o_alloc_addr,
    output logic [drpa_pkg::ST_W-1:0]     o_status,
    output logic [drpa_pkg::CNT_W-1:0]    o_free_count
);

    localparam int AW  = drpa_pkg::ADDR_W;
    localparam int AXW = drpa_pkg::ADDR_W + 1;
    localparam int CW  = drpa_pkg::CNT_W;
    localparam int PW  = $clog2(MAX_PAGES);
    localparam int LW  = $clog2(MAX_PAGES + 1);
    localparam logic [LW-1:0]  NIL       = LW'(MAX_PAGES);
    localparam logic [AXW-1:0] ADDR_TOP  = AXW'(1) << AW;

    // configuration
    logic [AW-1:0]  r_base;
    logic [CW-1:0]  r_kpages;
    logic [CW-1:0]  r_tpages;
    // latched region bounds
    logic [AW-1:0]  r_lat_base;
    logic [AXW-1:0] r_lat_kend;
    logic [AXW-1:0] r_lat_uend;
    // list state
    logic [LW-1:0]  r_khead;
    logic [LW-1:0]  r_uhead;
    logic [CW-1:0]  r_kcnt;
    logic [CW-1:0]  r_ucnt;
    // item and working registers
    logic           r_sel;
    logic [AW-1:0]  r_addr;
    logic [AW-1:0]  r_res_addr;
    drpa_pkg::t_status r_res_status;
    logic [AXW-1:0] r_kend_c;
    logic [AXW-1:0] r_uend_c;
    logic [LW-1:0]  r_fill;
    // output registers
    logic [AW-1:0]  r_out_addr;
    drpa_pkg::t_status r_out_status;
    logic [CW-1:0]  r_out_cnt;

    logic [LW-1:0]  sel_head;
    logic           head_empty;
    logic [AW-1:0]  head_addr;
    logic           misaligned;
    logic [AXW-1:0] lo_bound;
    logic [AXW-1:0] hi_bound;
    logic [AXW-1:0] addr_x;
    logic           out_of_range;
    logic [AW-1:0]  diff;
    logic [AW-1:0]  pg_full;
    logic           pg_ok;
    logic           free_ok;
    logic           cfg_ok;
    logic [LW-1:0]  fill_nx;
    logic           fill_last;
    logic [LW-1:0]  fill_link;
    logic           mem_we;
    logic [PW-1:0]  mem_addr;
    logic [LW-1:0]  mem_wdata;
    logic [LW-1:0]  mem_rdata;

    // alloc
    assign sel_head   = r_sel ? r_khead : r_uhead;
    assign head_empty = (sel_head >= NIL);
    assign head_addr  = r_lat_base + (AW'(sel_head) << PAGE_SHIFT);

    // free checks
    assign misaligned   = |r_addr[PAGE_SHIFT-1:0];
    assign lo_bound     = r_sel ? {1'b0, r_lat_base} : r_lat_kend;
    assign hi_bound     = r_sel ? r_lat_kend : r_lat_uend;
    assign addr_x       = {1'b0, r_addr};
    assign out_of_range = (addr_x < lo_bound) || (addr_x >= hi_bound);
    assign diff         = r_addr - r_lat_base;
    assign pg_full      = diff >> PAGE_SHIFT;
    assign pg_ok        = (pg_full < AW'(MAX_PAGES));
    assign free_ok      = (r_res_status == drpa_pkg::ST_OK) && pg_ok;

    // init checks, end addresses come from the previous cycle
    assign cfg_ok = !(|r_base[PAGE_SHIFT-1:0]) && (r_kpages <= r_tpages)
                  && (32'(r_tpages) <= 32'(MAX_PAGES)) && (r_uend_c <= ADDR_TOP);

    // fill sweep: each page links to the next, region ends link to NIL
    assign fill_nx   = r_fill + LW'(1);
    assign fill_last = (32'(fill_nx) == 32'(r_tpages));
    assign fill_link = (fill_last || (32'(fill_nx) == 32'(r_kpages))) ? NIL : fill_nx;

    // link memory port
    assign mem_we    = i_cmd.fill_step || (i_cmd.free_upd && free_ok);
    assign mem_wdata = i_cmd.fill_step ? fill_link : sel_head;
    always_comb begin
        if (i_cmd.fill_step) begin
            mem_addr = r_fill[PW-1:0];
        end else if (i_cmd.free_upd) begin
            mem_addr = pg_full[PW-1:0];
        end else begin
            mem_addr = sel_head[PW-1:0];
        end
    end

    drpa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // control state: config, bounds, heads, counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_kpages   <= '0;
            r_tpages   <= '0;
            r_lat_base <= '0;
            r_lat_kend <= '0;
            r_lat_uend <= '0;
            r_khead    <= NIL;
            r_uhead    <= NIL;
            r_kcnt     <= '0;
            r_ucnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    drpa_pkg::CFG_BASE:   r_base   <= i_cfg_data;
                    drpa_pkg::CFG_KPAGES: r_kpages <= i_cfg_data[CW-1:0];
                    drpa_pkg::CFG_TPAGES: r_tpages <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.alloc_upd) begin
                if (r_sel) begin
                    r_khead <= mem_rdata;
                    r_kcnt  <= r_kcnt - CW'(1);
                end else begin
                    r_uhead <= mem_rdata;
                    r_ucnt  <= r_ucnt - CW'(1);
                end
            end
            if (i_cmd.free_upd && free_ok) begin
                if (r_sel) begin
                    r_khead <= LW'(pg_full);
                    r_kcnt  <= r_kcnt + CW'(1);
                end else begin
                    r_uhead <= LW'(pg_full);
                    r_ucnt  <= r_ucnt + CW'(1);
                end
            end
            if (i_cmd.init_dec && cfg_ok) begin
                r_lat_base <= r_base;
                r_lat_kend <= r_kend_c;
                r_lat_uend <= r_uend_c;
                r_khead    <= (r_kpages != '0) ? '0 : NIL;
                r_uhead    <= (r_kpages < r_tpages) ? LW'(r_kpages) : NIL;
                r_kcnt     <= r_kpages;
                r_ucnt     <= r_tpages - r_kpages;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_sel        <= i_region_select;
            r_addr       <= i_page_addr;
            r_res_addr   <= '0;
            r_res_status <= drpa_pkg::ST_OK;
        end
        if (i_cmd.alloc_chk) begin
            if (head_empty) begin
                r_res_status <= drpa_pkg::ST_OOM;
            end else begin
                r_res_addr <= head_addr;
            end
        end
        if (i_cmd.free_chk) begin
            if (misaligned) begin
                r_res_status <= drpa_pkg::ST_MISALIGN;
            end else if (out_of_range) begin
                r_res_status <= drpa_pkg::ST_RANGE;
            end
        end
        if (i_cmd.free_upd && (r_res_status == drpa_pkg::ST_OK) && !pg_ok) begin
            r_res_status <= drpa_pkg::ST_RANGE;
        end
        if (i_cmd.init_chk) begin
            r_kend_c <= {1'b0, r_base} + (AXW'(r_kpages) << PAGE_SHIFT);
            r_uend_c <= {1'b0, r_base} + (AXW'(r_tpages) << PAGE_SHIFT);
        end
        if (i_cmd.init_dec) begin
            r_fill <= '0;
            if (!cfg_ok) begin
                r_res_status <= drpa_pkg::ST_BADCFG;
            end
        end
        if (i_cmd.fill_step) begin
            r_fill <= fill_nx;
        end
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_cnt    <= r_sel ? r_kcnt : r_ucnt;
        end
    end

    assign o_stat.head_empty = head_empty;
    assign o_stat.cfg_ok     = cfg_ok;
    assign o_stat.fill_none  = (r_tpages == '0);
    assign o_stat.fill_last  = fill_last;

    assign o_alloc_addr = r_out_addr;
    assign o_status     = r_out_status;
    assign o_free_count = r_out_cnt;

    // sweep index stays inside the configured page span
    a_fill_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> (32'(r_fill) < 32'(r_tpages)))
        else $error("fill index beyond total pages");

    // a successful init leaves the kernel head at page zero or empty
    a_init_khead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.init_dec && cfg_ok) |=> (r_khead == '0 || r_khead == NIL))
        else $error("kernel head wrong after init");

    // popping a non-empty list reports success
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alloc_chk && !head_empty) |=> (r_res_status == drpa_pkg::ST_OK))
        else $error("alloc of non-empty list flagged an error");

endmodule

FILE: sim/tb_dual_region_page_allocator.sv
// tb_dual_region_page_allocator: self-checking testbench for the two-region page allocator.
// Depends on drpa_pkg and dual_region_page_allocator; carries its own free-list predictor.
module tb_dual_region_page_allocator;
    import drpa_pkg::*;

    localparam int MAX_PAGES    = 4096;
    localparam int PAGE_SHIFT   = 12;
    localparam int RANDOM_ITEMS = 1950;
    localparam logic [CNT_W-1:0] NIL_PAGE   = 13'(MAX_PAGES);
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;    // index with no register behind it
    localparam logic [63:0]      ADDR_SPAN  = 64'd1 << ADDR_W;
    // base that puts a full 4096-page layout flush against the top of the address space
    localparam logic [ADDR_W-1:0] TOP_FULL_BASE = 48'hFFFF_FF00_0000;
    localparam logic [ADDR_W-1:0] TOP_PAGE      = 48'hFFFF_FFFF_F000;

    // one reply item as the block should produce it
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } page_reply_t;

    // DUT ports; every input is known from time zero
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx       = CFG_BASE;
    logic [ADDR_W-1:0]  i_cfg_data      = '0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_opcode        = '0;
    logic               i_region_select = 1'b0;
    logic [ADDR_W-1:0]  i_page_addr     = '0;
    logic               o_out_valid;
    logic               i_out_ready     = 1'b0;
    logic [ADDR_W-1:0]  o_alloc_addr;
    logic [ST_W-1:0]    o_status;
    logic [CNT_W-1:0]   o_free_count;

    dual_region_page_allocator #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_region_select(i_region_select),
        .i_page_addr    (i_page_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_alloc_addr   (o_alloc_addr),
        .o_status       (o_status),
        .o_free_count   (o_free_count)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: shadow registers, link memory, heads, counts and
    // the region bounds latched by the last good init. Matches reset.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] cfg_base   = '0;
    logic [CNT_W-1:0]  cfg_kpages = '0;
    logic [CNT_W-1:0]  cfg_tpages = '0;

    logic [CNT_W-1:0]  link_mem [0:MAX_PAGES-1];
    logic [CNT_W-1:0]  kern_head  = NIL_PAGE;
    logic [CNT_W-1:0]  user_head  = NIL_PAGE;
    logic [CNT_W-1:0]  kern_free  = '0;
    logic [CNT_W-1:0]  user_free  = '0;
    logic [63:0]       bound_base = '0;
    logic [63:0]       bound_kend = '0;
    logic [63:0]       bound_uend = '0;

    page_reply_t       replies_due [$];     // predicted replies, oldest first
    page_reply_t       last_reply;
    page_reply_t       want_reply;
    logic [ADDR_W-1:0] kern_held [$];       // pages handed out and not yet returned
    logic [ADDR_W-1:0] user_held [$];
    int                mismatch_count = 0;

    // flow control knobs shared by the tests and the two handshake sides
    bit                tx_no_gaps      = 1'b0;
    int                tx_burst_left   = 0;
    bit                rx_always_ready = 1'b0;
    int                rx_hold_left    = 0;
    logic [15:0]       rx_pattern      = 16'hFFFF;
    logic [3:0]        rx_slot         = '0;

    function automatic logic [ADDR_W-1:0] rand48();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        return {a[15:0], b};
    endfunction

    // Apply one request to the predictor state and return the reply it should give.
    function automatic page_reply_t predict_page_op(t_op op, logic sel, logic [ADDR_W-1:0] addr);
        page_reply_t r;
        logic [CNT_W-1:0] h;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] pg;
        logic [63:0] cend;
        int i;
        r.addr   = '0;
        r.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                h = sel ? kern_head : user_head;
                if (h >= NIL_PAGE) begin
                    r.status = ST_OOM;
                end else begin
                    r.addr = 48'(bound_base + (64'(h) << PAGE_SHIFT));
                    if (sel) begin
                        kern_head = link_mem[int'(h)];
                        kern_free = kern_free - 13'd1;
                    end else begin
                        user_head = link_mem[int'(h)];
                        user_free = user_free - 13'd1;
                    end
                end
            end
            OP_FREE: begin
                lo = sel ? bound_base : bound_kend;
                hi = sel ? bound_kend : bound_uend;
                // alignment wins over range
                if (addr[PAGE_SHIFT-1:0] != '0) begin
                    r.status = ST_MISALIGN;
                end else if (64'(addr) < lo || 64'(addr) >= hi) begin
                    r.status = ST_RANGE;
                end else begin
                    pg = (64'(addr) - bound_base) >> PAGE_SHIFT;
                    if (pg >= 64'(MAX_PAGES)) begin
                        r.status = ST_RANGE;
                    end else if (sel) begin
                        // no double-free detection: the page is simply pushed again
                        link_mem[int'(pg)] = kern_head;
                        kern_head = 13'(pg);
                        kern_free = kern_free + 13'd1;
                    end else begin
                        link_mem[int'(pg)] = user_head;
                        user_head = 13'(pg);
                        user_free = user_free + 13'd1;
                    end
                end
            end
            OP_INIT: begin
                cend = 64'(cfg_base) + (64'(cfg_tpages) << PAGE_SHIFT);
                if (cfg_base[PAGE_SHIFT-1:0] != '0 || cfg_kpages > cfg_tpages ||
                    cfg_tpages > 13'(MAX_PAGES) || cend > ADDR_SPAN) begin
                    r.status = ST_BADCFG;     // nothing changes
                end else begin
                    bound_base = 64'(cfg_base);
                    bound_kend = 64'(cfg_base) + (64'(cfg_kpages) << PAGE_SHIFT);
                    bound_uend = cend;
                    // each region becomes an ascending chain ending in the null page
                    for (i = 0; i < int'(cfg_tpages); i++) begin
                        if (i < int'(cfg_kpages))
                            link_mem[i] = (i + 1 < int'(cfg_kpages)) ? 13'(i + 1) : NIL_PAGE;
                        else
                            link_mem[i] = (i + 1 < int'(cfg_tpages)) ? 13'(i + 1) : NIL_PAGE;
                    end
                    kern_head = (cfg_kpages != '0) ? 13'd0 : NIL_PAGE;
                    user_head = (cfg_kpages < cfg_tpages) ? cfg_kpages : NIL_PAGE;
                    kern_free = cfg_kpages;
                    user_free = cfg_tpages - cfg_kpages;
                end
            end
            default: ;   // unused opcode: no effect
        endcase
        r.count = sel ? kern_free : user_free;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request item; predicts its reply once it is taken. Valid is
    // left high when the next item follows straight away.
    task automatic send_page_op(input t_op op, input logic sel, input logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_region_select <= sel;
        i_page_addr     <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        last_reply = predict_page_op(op, sel, addr);
        replies_due.push_back(last_reply);
        // keep track of pages the stimulus may hand back later
        if (op == OP_ALLOC && last_reply.status == ST_OK) begin
            if (sel) kern_held.push_back(last_reply.addr);
            else user_held.push_back(last_reply.addr);
        end
        if (op == OP_INIT && last_reply.status == ST_OK) begin
            kern_held.delete();
            user_held.delete();
        end
        // bursts of random length separated by random gaps
        if (!tx_no_gaps) begin
            if (tx_burst_left > 0) tx_burst_left--;
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 24);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end
        end
    endtask

    task automatic tx_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Stop offering and wait until every predicted reply has been seen.
    task automatic wait_replies_drained();
        tx_idle();
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_BASE:   cfg_base   = data;
            CFG_KPAGES: cfg_kpages = data[CNT_W-1:0];
            CFG_TPAGES: cfg_tpages = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, then load all three layout registers. With junk set, the
    // bits above the count width carry garbage that must be dropped.
    task automatic program_layout(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] kp,
                                  input logic [CNT_W-1:0] tp, input logic junk);
        logic [ADDR_W-1:0] noise;
        logic [ADDR_W-CNT_W-1:0] hi_bits;
        noise   = rand48();
        hi_bits = junk ? noise[ADDR_W-1:CNT_W] : '0;
        wait_replies_drained();
        write_cfg(CFG_BASE, base);
        write_cfg(CFG_KPAGES, {hi_bits, kp});
        write_cfg(CFG_TPAGES, {hi_bits, tp});
    endtask

    // ------------------------------------------------------------------
    // Reply side: stall pattern re-rolled each time the 4-bit slot counter wraps, an
    // optional long hold-off counted here, or always ready.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_always_ready) begin
            i_out_ready <= 1'b1;
        end else begin
            if (rx_slot == 4'd0) begin
                case ($urandom_range(0, 3))
                    0:       rx_pattern = 16'hFFFF;
                    1:       rx_pattern = 16'($urandom) | 16'($urandom);
                    2:       rx_pattern = 16'($urandom);
                    default: rx_pattern = 16'($urandom) & 16'($urandom);
                endcase
            end
            i_out_ready <= rx_pattern[rx_slot];
            rx_slot = rx_slot + 4'd1;
        end
    end

    // Compare every reply taken against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (replies_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected reply: addr=%h status=%0d count=%0d",
                             o_alloc_addr, o_status, o_free_count);
                mismatch_count++;
            end else begin
                want_reply = replies_due.pop_front();
                if (o_alloc_addr !== want_reply.addr || o_status !== want_reply.status ||
                    o_free_count !== want_reply.count) begin
                    if (mismatch_count < 10)
                        $display({"reply mismatch: want addr=%h status=%0d count=%0d,",
                                  " got addr=%h status=%0d count=%0d"},
                                 want_reply.addr, want_reply.status, want_reply.count,
                                 o_alloc_addr, o_status, o_free_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Straight out of reset both lists are empty and all bounds are zero.
    task automatic test_before_init();
        send_page_op(OP_ALLOC, 1'b1, '0);
        send_page_op(OP_ALLOC, 1'b0, rand48());
        send_page_op(OP_FREE, 1'b0, '0);
        send_page_op(OP_FREE, 1'b1, 48'h1000);
        send_page_op(OP_NOP, 1'b1, 48'hFFFF_FFFF_FFFF);
    endtask

    // Every way init can reject the layout; state must stay untouched.
    task automatic test_bad_config();
        program_layout(48'h1, 13'd2, 13'd4, 1'b0);                 // base not page aligned
        send_page_op(OP_INIT, 1'b1, '0);
        program_layout(48'h0, 13'd5, 13'd4, 1'b0);                 // kernel larger than total
        send_page_op(OP_INIT, 1'b0, '0);
        program_layout(48'h0, 13'd0, 13'd4097, 1'b1);              // total above capacity
        send_page_op(OP_INIT, 1'b0, '0);
        program_layout(TOP_PAGE, 13'd0, 13'd2, 1'b0);              // end past 48 bits
        send_page_op(OP_INIT, 1'b1, '0);
        send_page_op(OP_ALLOC, 1'b0, '0);
    endtask

    // Largest layouts, at the top and the bottom of the address space.
    task automatic test_extreme_layouts();
        program_layout(TOP_FULL_BASE, 13'd0, 13'd4096, 1'b0);      // all user, ends at 2^48
        send_page_op(OP_INIT, 1'b0, '0);
        send_page_op(OP_ALLOC, 1'b0, '0);
        send_page_op(OP_ALLOC, 1'b1, '0);                          // empty kernel list
        send_page_op(OP_FREE, 1'b0, TOP_PAGE);                     // double free of a free page
        send_page_op(OP_FREE, 1'b0, 48'hFFFF_FFFF_FFFF);           // misaligned
        send_page_op(OP_FREE, 1'b1, TOP_FULL_BASE);                // kernel region is empty
        send_page_op(OP_ALLOC, 1'b0, '0);                          // LIFO: top page comes back
        program_layout(48'h0, 13'd4096, 13'd4096, 1'b0);           // all kernel
        send_page_op(OP_INIT, 1'b1, '0);
        send_page_op(OP_ALLOC, 1'b1, '0);
        send_page_op(OP_ALLOC, 1'b1, '0);
        send_page_op(OP_FREE, 1'b1, 48'h0);
        send_page_op(OP_FREE, 1'b0, 48'h100_0000);                 // user region is empty
        send_page_op(OP_ALLOC, 1'b0, '0);
        program_layout(48'h0, 13'd0, 13'd0, 1'b0);                 // no pages at all
        send_page_op(OP_INIT, 1'b0, '0);
        send_page_op(OP_ALLOC, 1'b1, '0);
    endtask

    // Long reply hold-off while requests keep coming, so the input stalls;
    // then a full pause until every reply is back.
    task automatic test_backpressure();
        int i;
        program_layout(48'h0000_0040_0000, 13'd8, 13'd16, 1'b0);
        send_page_op(OP_INIT, 1'b0, '0);
        wait_replies_drained();
        tx_no_gaps   = 1'b1;
        rx_hold_left = 400;
        for (i = 0; i < 32; i++) begin
            if (i < 24)
                send_page_op(OP_ALLOC, 1'(i % 2), rand48());
            else if (kern_held.size() != 0)
                send_page_op(OP_FREE, 1'b1, kern_held.pop_back());
            else if (user_held.size() != 0)
                send_page_op(OP_FREE, 1'b0, user_held.pop_back());
            else
                send_page_op(OP_ALLOC, 1'b0, rand48());
        end
        wait_replies_drained();
        tx_no_gaps = 1'b0;
        send_page_op(OP_ALLOC, 1'b1, '0);
        send_page_op(OP_ALLOC, 1'b0, '0);
        wait_replies_drained();
    endtask

    // Phases of random layout followed by mostly well-formed alloc/free
    // traffic, with some malformed frees, re-inits and noise mixed in.
    task automatic test_random_phases();
        int sent;
        int n;
        int r;
        int k;
        int pb;
        t_op op;
        logic sel;
        logic full;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] noise;
        logic [CNT_W-1:0] kp;
        logic [CNT_W-1:0] tp;
        logic [63:0] pn;
        logic [63:0] lo;
        logic [63:0] hi;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // choose a layout: mostly small, now and then large, sometimes broken
            r = $urandom_range(0, 19);
            tp = (r == 0) ? 13'($urandom_range(2048, MAX_PAGES)) : 13'($urandom_range(0, 48));
            kp = 13'($urandom_range(0, int'(tp)));
            noise = rand48();
            pn = {28'd0, noise[35:0]};
            case ($urandom_range(0, 7))
                0:       pn = 64'd0;
                1:       pn = (64'd1 << 36) - 64'(tp);
                default: if (pn > (64'd1 << 36) - 64'(tp)) pn = (64'd1 << 36) - 64'(tp);
            endcase
            base = 48'(pn << PAGE_SHIFT);
            if (r == 1 || r == 2) begin
                case ($urandom_range(0, 3))
                    0: base[PAGE_SHIFT-1:0] = 12'($urandom_range(1, 4095));
                    1: kp = 13'($urandom_range(int'(tp) + 1, MAX_PAGES));
                    2: tp = 13'($urandom_range(MAX_PAGES + 1, 8191));
                    default: begin
                        tp = 13'($urandom_range(2, 48));
                        kp = 13'($urandom_range(0, int'(tp)));
                        pb = $urandom_range(0, int'(tp) - 2);
                        base = 48'(ADDR_SPAN - 64'(4096) - (64'(pb) << PAGE_SHIFT));
                    end
                endcase
            end
            program_layout(base, kp, tp, 1'($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED, rand48());
            full = 1'($urandom_range(0, 4) == 0);
            tx_no_gaps      = full;
            rx_always_ready = full;
            send_page_op(OP_INIT, 1'($urandom_range(0, 1)), rand48());
            sent++;

            n = $urandom_range(40, 140);
            repeat (n) begin
                r    = $urandom_range(0, 99);
                sel  = 1'($urandom_range(0, 1));
                addr = rand48();
                lo   = sel ? bound_base : bound_kend;
                hi   = sel ? bound_kend : bound_uend;
                if (r < 40) begin
                    op = OP_ALLOC;
                end else if (r < 75) begin
                    // hand back a page that was allocated earlier
                    op = OP_FREE;
                    if (sel ? (kern_held.size() == 0) : (user_held.size() == 0)) sel = !sel;
                    if (sel && kern_held.size() != 0) begin
                        k = $urandom_range(0, kern_held.size() - 1);
                        addr = kern_held[k];
                        kern_held.delete(k);
                    end else if (!sel && user_held.size() != 0) begin
                        k = $urandom_range(0, user_held.size() - 1);
                        addr = user_held[k];
                        user_held.delete(k);
                    end else begin
                        op = OP_ALLOC;
                    end
                end else if (r < 80) begin
                    // any page of the region, often one already free
                    op = OP_FREE;
                    if (hi > lo)
                        addr = 48'(lo + (64'($urandom_range(0, int'((hi - lo) >> PAGE_SHIFT) - 1))
                                         << PAGE_SHIFT));
                end else if (r < 85) begin
                    op = OP_FREE;
                    addr[PAGE_SHIFT-1:0] = 12'($urandom_range(1, 4095));
                end else if (r < 90) begin
                    // aligned but outside the selected region, or right at its edges
                    op = OP_FREE;
                    case ($urandom_range(0, 3))
                        0:       addr[PAGE_SHIFT-1:0] = '0;
                        1:       addr = 48'(lo - 64'(4096));
                        2:       addr = 48'(hi);
                        default: addr = 48'(sel ? bound_kend : bound_base);
                    endcase
                end else if (r < 93) begin
                    op = OP_NOP;
                end else if (r < 95) begin
                    op = OP_INIT;
                end else begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_ALLOC;
                        1:       op = OP_FREE;
                        default: op = OP_NOP;
                    endcase
                    if ($urandom_range(0, 1) == 0) addr[PAGE_SHIFT-1:0] = '0;
                end
                send_page_op(op, sel, addr);
                sent++;
            end
        end
        wait_replies_drained();
        tx_no_gaps      = 1'b0;
        rx_always_ready = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, directed tests, random phases, then drain.
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_before_init();
        test_bad_config();
        test_extreme_layouts();
        test_backpressure();
        test_random_phases();
        wait_replies_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, several times the slowest legal run (full inits included).
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
